### src/fbat_pkg.sv
`default_nettype none
package fbat_pkg;

  localparam int MaxPeers = 8;

  localparam int CfgIdxW = 3;
  localparam int SDataW  = 168;
  localparam int MDataW  = 80;

  localparam logic [7:0]  BcastDst  = 8'd255;
  localparam logic [9:0]  CodeBcast = 10'd777;
  localparam logic [9:0]  CodeAck   = 10'd778;

  localparam logic [7:0]  NodeIdRst     = 8'd1;
  localparam logic [3:0]  PeerCountRst  = 4'd8;
  localparam logic [63:0] PeerIdsRst    = 64'd0;
  localparam logic [31:0] TimeoutRst    = 32'd10000000;
  localparam logic [7:0]  InitialTtlRst = 8'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_ID     = 3'd0,
    CFG_PEER_COUNT  = 3'd1,
    CFG_PEER_IDS    = 3'd2,
    CFG_TIMEOUT_US  = 3'd3,
    CFG_INITIAL_TTL = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [3:0]  peer_count;
    logic [63:0] peer_ids;
    logic [31:0] timeout_us;
    logic [7:0]  initial_ttl;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic        button_level;
    logic [62:0] now_us;
    logic [31:0] new_msg_id;
    logic [7:0]  pkt_src;
    logic [7:0]  pkt_dst;
    logic [9:0]  pkt_code;
    logic [7:0]  pkt_ttl;
    logic [31:0] pkt_msg_id;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_src;
    logic [7:0]  out_dst;
    logic [9:0]  out_code;
    logic [7:0]  out_ttl;
    logic [31:0] out_msg_id;
    logic [7:0]  ack_mask;
    logic [3:0]  ack_tally;
    logic        last;
  } result_t;

  function automatic result_t make_send(logic [7:0] src, logic [7:0] dst,
                                        logic [9:0] code, logic [7:0] ttl,
                                        logic [31:0] msg_id);
    result_t r;
    r            = '0;
    r.kind       = KIND_SEND;
    r.out_src    = src;
    r.out_dst    = dst;
    r.out_code   = code;
    r.out_ttl    = ttl;
    r.out_msg_id = msg_id;
    return r;
  endfunction

  function automatic result_t make_report(kind_t kind, logic [7:0] mask,
                                          logic [3:0] tally);
    result_t r;
    r           = '0;
    r.kind      = kind;
    r.ack_mask  = mask;
    r.ack_tally = tally;
    return r;
  endfunction

endpackage
`default_nettype wire

### src/fbat_cfg_regs.sv
`default_nettype none
module fbat_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fbat_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [63:0]                   cfg_data,
  output fbat_pkg::cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id     <= fbat_pkg::NodeIdRst;
      cfg.peer_count  <= fbat_pkg::PeerCountRst;
      cfg.peer_ids    <= fbat_pkg::PeerIdsRst;
      cfg.timeout_us  <= fbat_pkg::TimeoutRst;
      cfg.initial_ttl <= fbat_pkg::InitialTtlRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fbat_pkg::CFG_NODE_ID:     cfg.node_id     <= cfg_data[7:0];
        fbat_pkg::CFG_PEER_COUNT:  cfg.peer_count  <= cfg_data[3:0];
        fbat_pkg::CFG_PEER_IDS:    cfg.peer_ids    <= cfg_data;
        fbat_pkg::CFG_TIMEOUT_US:  cfg.timeout_us  <= cfg_data[31:0];
        fbat_pkg::CFG_INITIAL_TTL: cfg.initial_ttl <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/fbat_engine.sv
`default_nettype none
module fbat_engine #(
  parameter int MAX_PEERS = fbat_pkg::MaxPeers
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fbat_pkg::cfg_t   cfg,
  input  wire fbat_pkg::item_t  item,
  input  wire logic             go,
  output fbat_pkg::result_t     res0,
  output fbat_pkg::result_t     res1,
  output logic [1:0]            nres
);

  logic                 waiting, waiting_next;
  logic [31:0]          pending_id, pending_id_next;
  logic [62:0]          wait_start, wait_start_next;
  logic [MAX_PEERS-1:0] acked_peers, acked_peers_next;
  logic [3:0]           acked_total, acked_total_next;
  logic                 prev_button, prev_button_next;

  always_comb begin
    logic [3:0]        eff;
    logic              start;
    logic [63:0]       diff;
    logic              found;
    logic [MAX_PEERS-1:0] hit;
    fbat_pkg::result_t rpt;
    fbat_pkg::result_t fwd;

    waiting_next     = waiting;
    pending_id_next  = pending_id;
    wait_start_next  = wait_start;
    acked_peers_next = acked_peers;
    acked_total_next = acked_total;
    prev_button_next = prev_button;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;
    found = 1'b0;
    hit = '0;
    start = 1'b0;
    diff = '0;
    rpt = '0;

    eff = (cfg.peer_count > 4'(MAX_PEERS)) ? 4'(MAX_PEERS) : cfg.peer_count;
    fwd = fbat_pkg::make_send(item.pkt_src, item.pkt_dst, item.pkt_code,
                              item.pkt_ttl - 8'd1, item.pkt_msg_id);

    if (item.req_type) begin
      start = !item.button_level && prev_button && !waiting;
      if (start) begin
        res0 = fbat_pkg::make_send(cfg.node_id, fbat_pkg::BcastDst,
                                   fbat_pkg::CodeBcast, cfg.initial_ttl,
                                   item.new_msg_id);
        nres = 2'd1;
        acked_peers_next = '0;
        acked_total_next = 4'd0;
        pending_id_next  = item.new_msg_id;
        waiting_next     = 1'b1;
        wait_start_next  = item.now_us;
      end
      diff = {1'b0, item.now_us} - {1'b0, wait_start};
      rpt = fbat_pkg::make_report(fbat_pkg::KIND_DONE, 8'(acked_peers_next),
                                  acked_total_next);
      if (waiting_next && acked_total_next >= eff) begin
        waiting_next = 1'b0;
      end else if (waiting_next && !start && !diff[63] &&
                   diff[62:0] > {31'd0, cfg.timeout_us}) begin
        rpt.kind = fbat_pkg::KIND_TIMEOUT;
        waiting_next = 1'b0;
      end
      // a report follows the broadcast if one went out in this poll
      if (waiting && !waiting_next || start && !waiting_next) begin
        if (start) res1 = rpt;
        else res0 = rpt;
        nres = nres + 2'd1;
      end
      prev_button_next = item.button_level;
    end else if (item.pkt_dst == fbat_pkg::BcastDst &&
                 item.pkt_code == fbat_pkg::CodeBcast) begin
      res0 = fbat_pkg::make_send(cfg.node_id, item.pkt_src, fbat_pkg::CodeAck,
                                 cfg.initial_ttl, item.pkt_msg_id);
      nres = 2'd1;
      if (item.pkt_ttl > 8'd1) begin
        res1 = fwd;
        nres = 2'd2;
      end
    end else if (item.pkt_code == fbat_pkg::CodeAck) begin
      if (item.pkt_ttl > 8'd1) begin
        res0 = fwd;
        nres = 2'd1;
      end
      if (item.pkt_dst == cfg.node_id && waiting &&
          item.pkt_msg_id == pending_id) begin
        // first listed peer with a matching id wins
        for (int i = 0; i < MAX_PEERS; i++) begin
          if (!found && 4'(i) < eff &&
              cfg.peer_ids[8*i +: 8] == item.pkt_src) begin
            found  = 1'b1;
            hit[i] = 1'b1;
          end
        end
        if (found && (acked_peers & hit) == '0) begin
          acked_peers_next = acked_peers | hit;
          acked_total_next = acked_total + 4'd1;
        end
      end
    end

    if (nres == 2'd1) res0.last = 1'b1;
    if (nres == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting     <= 1'b0;
      pending_id  <= '0;
      wait_start  <= '0;
      acked_peers <= '0;
      acked_total <= '0;
      prev_button <= 1'b1;
    end else if (go) begin
      waiting     <= waiting_next;
      pending_id  <= pending_id_next;
      wait_start  <= wait_start_next;
      acked_peers <= acked_peers_next;
      acked_total <= acked_total_next;
      prev_button <= prev_button_next;
    end
  end

endmodule
`default_nettype wire

### src/fbat_result_q.sv
`default_nettype none
module fbat_result_q (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire fbat_pkg::result_t  wr0,
  input  wire fbat_pkg::result_t  wr1,
  input  wire logic [1:0]         wr_n,
  output logic                    room,
  output logic                    rd_valid,
  input  wire logic               rd_ready,
  output fbat_pkg::result_t       rd_data
);

  fbat_pkg::result_t entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic [2:0] n_in;
  logic       pop;

  // room for the two results an item may cause
  assign room     = count <= 3'd2;
  assign rd_valid = count != 3'd0;
  assign rd_data  = entries[rd_ptr];
  assign pop      = rd_valid && rd_ready;
  assign n_in     = wr_en ? {1'b0, wr_n} : 3'd0;
  assign count_next = count + n_in - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_in[1:0];
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_n != 2'd0) entries[wr_ptr] <= wr0;
    if (wr_en && wr_n == 2'd2) entries[wr_ptr + 2'd1] <= wr1;
  end

endmodule
`default_nettype wire

### src/flood_broadcast_ack_tracker.sv
`default_nettype none
// Flood-broadcast engine with acknowledgement collection. A request on the
// s_ side is either a received packet or a poll (s_tuser = 1) carrying the
// button level and the time; each request yields zero, one or two results on
// the m_ side, the final one marked by m_tlast. A request is registered, then
// processed combinationally against the tracker state and pushed into a
// four-entry result queue, from which results are offered on m_; the push
// waits while the queue has fewer than two free entries. One request per
// cycle is taken while each yields at most one result and m_ is not
// stalled; a request with two results puts both through the single output
// port in turn, so such traffic fills the queue and holds off requests. The
// configuration port is always ready and a write takes effect on the next
// cycle.
module flood_broadcast_ack_tracker #(
  parameter int MAX_PEERS = fbat_pkg::MaxPeers
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // button_level, now_us, new_msg_id, pkt_src, pkt_dst, pkt_code, pkt_ttl,
  // pkt_msg_id, zero pad
  input  wire logic [fbat_pkg::SDataW-1:0]   s_tdata,
  // req_type
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // out_src, out_dst, out_code, out_ttl, out_msg_id, ack_mask, ack_tally,
  // zero pad
  output logic [fbat_pkg::MDataW-1:0]        m_tdata,
  // kind
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fbat_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [63:0]                   cfg_data
);

  fbat_pkg::cfg_t    cfg;
  fbat_pkg::item_t   in_item, s_item;
  logic              in_valid;
  logic              room, advance;
  fbat_pkg::result_t res0, res1, rd_data;
  logic [1:0]        nres;

  assign s_item.req_type     = s_tuser;
  assign s_item.button_level = s_tdata[0];
  assign s_item.now_us       = s_tdata[63:1];
  assign s_item.new_msg_id   = s_tdata[95:64];
  assign s_item.pkt_src      = s_tdata[103:96];
  assign s_item.pkt_dst      = s_tdata[111:104];
  assign s_item.pkt_code     = s_tdata[121:112];
  assign s_item.pkt_ttl      = s_tdata[129:122];
  assign s_item.pkt_msg_id   = s_tdata[161:130];

  assign advance  = in_valid && room;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_item <= s_item;
  end

  fbat_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fbat_engine #(
    .MAX_PEERS (MAX_PEERS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .go   (advance),
    .res0 (res0),
    .res1 (res1),
    .nres (nres)
  );

  fbat_result_q u_q (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (advance),
    .wr0      (res0),
    .wr1      (res1),
    .wr_n     (nres),
    .room     (room),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (rd_data)
  );

  assign m_tdata = {2'b00, rd_data.ack_tally, rd_data.ack_mask, rd_data.out_msg_id,
                    rd_data.out_ttl, rd_data.out_code, rd_data.out_dst,
                    rd_data.out_src};
  assign m_tuser = rd_data.kind;
  assign m_tlast = rd_data.last;

endmodule
`default_nettype wire
